// ===== src/palette_colour_to_index_defines.svh =====
// Assertion macros shared by the palette indexer checkers.
`ifndef PALETTE_COLOUR_TO_INDEX_DEFINES_SVH
`define PALETTE_COLOUR_TO_INDEX_DEFINES_SVH

// Check a property on every clock edge outside reset.
`define PCTI_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Check a property on every clock edge, reset included.
`define PCTI_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) (prop)) else $error(msg);

`endif

// ===== src/pcti_pkg.sv =====
// Types, constants and request codes of the palette colour indexer.
package pcti_pkg;

   localparam int TABLE_DEPTH   = 256;
   localparam int MISSING_DEPTH = 16;
   localparam int INDEX_BITS    = 8;
   localparam int TOTAL_CELLS   = TABLE_DEPTH + MISSING_DEPTH;

   typedef enum logic [1:0] {
      KIND_LOAD  = 2'd0,
      KIND_PIXEL = 2'd1,
      KIND_CLEAR = 2'd2
   } kind_type;

   typedef logic [INDEX_BITS-1:0] index_type;
   typedef logic [7:0]            field_index_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [31:0] colour;
      logic [7:0]  column;
      logic [9:0]  row;
   } req_payload_type;

   typedef struct packed {
      logic            found;
      field_index_type index;
      logic            duplicate_error;
      logic            first_missing;
      logic            missing_full;
      logic            table_full;
      logic            row_ignored;
   } rsp_payload_type;

   // Request state as it travels down the cell chain.
   typedef struct packed {
      logic        valid;
      logic [1:0]  kind;
      logic [31:0] colour;
      index_type   column;
      logic        ignored;   // load skipped by top line mode
      logic        hit;       // colour matched a palette entry
      index_type   index;     // index of the matching entry
      logic        placed;    // load written into a free entry
      logic        seen;      // pixel colour already in missing store
      logic        recorded;  // pixel colour written into missing store
   } token_type;

endpackage

// ===== src/pcti_entry_cell.sv =====
// One palette entry cell: holds a colour and its index, matches and fills in passing.
module pcti_entry_cell (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 advance,
   input  pcti_pkg::token_type  tok_in,
   output pcti_pkg::token_type  tok_out
);

   logic                 valid_ff;
   logic                 valid_in;
   logic [31:0]          colour_ff;
   pcti_pkg::index_type  index_ff;
   logic                 write;
   logic                 match;
   pcti_pkg::token_type  tok_ff;
   pcti_pkg::token_type  tok_in_next;

   assign match = valid_ff && (colour_ff == tok_in.colour);

   always_comb begin
      tok_in_next = tok_in;
      valid_in    = valid_ff;
      write       = 1'b0;
      if (tok_in.valid) begin
         case (tok_in.kind)
            pcti_pkg::KIND_LOAD: begin
               if (!tok_in.ignored && !tok_in.hit) begin
                  if (match) begin
                     tok_in_next.hit = 1'b1;
                  end else if (!valid_ff && !tok_in.placed) begin
                     write              = 1'b1;
                     valid_in           = 1'b1;
                     tok_in_next.placed = 1'b1;
                  end
               end
            end
            pcti_pkg::KIND_PIXEL: begin
               if (!tok_in.hit && match) begin
                  tok_in_next.hit   = 1'b1;
                  tok_in_next.index = index_ff;
               end
            end
            pcti_pkg::KIND_CLEAR: begin
               valid_in = 1'b0;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         tok_ff   <= '0;
      end else if (advance) begin
         valid_ff <= valid_in;
         tok_ff   <= tok_in_next;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && write) begin
         colour_ff <= tok_in.colour;
         index_ff  <= tok_in.column;
      end
   end

   assign tok_out = tok_ff;

endmodule

// ===== src/pcti_miss_cell.sv =====
// One missing-colour cell: holds a missed colour, matches and records in passing.
module pcti_miss_cell (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 advance,
   input  pcti_pkg::token_type  tok_in,
   output pcti_pkg::token_type  tok_out
);

   logic                 valid_ff;
   logic                 valid_in;
   logic [31:0]          colour_ff;
   logic                 write;
   pcti_pkg::token_type  tok_ff;
   pcti_pkg::token_type  tok_in_next;

   always_comb begin
      tok_in_next = tok_in;
      valid_in    = valid_ff;
      write       = 1'b0;
      if (tok_in.valid) begin
         case (tok_in.kind)
            pcti_pkg::KIND_PIXEL: begin
               if (!tok_in.hit && !tok_in.seen && !tok_in.recorded) begin
                  if (valid_ff && (colour_ff == tok_in.colour)) begin
                     tok_in_next.seen = 1'b1;
                  end else if (!valid_ff) begin
                     write                = 1'b1;
                     valid_in             = 1'b1;
                     tok_in_next.recorded = 1'b1;
                  end
               end
            end
            pcti_pkg::KIND_CLEAR: begin
               valid_in = 1'b0;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         tok_ff   <= '0;
      end else if (advance) begin
         valid_ff <= valid_in;
         tok_ff   <= tok_in_next;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && write) begin
         colour_ff <= tok_in.colour;
      end
   end

   assign tok_out = tok_ff;

endmodule

// ===== src/palette_colour_to_index.sv =====
// Top level of the exact-match palette colour indexer.
//
// Palette colour indexer. Each request is a load (enter a palette colour
// with its column as index), a pixel (look a 32-bit RGBA colour up), or a
// clear (empty the palette and the missing-colour store); every request
// yields exactly one response. Requests flow through a chain of
// TABLE_DEPTH palette cells followed by MISSING_DEPTH missing-colour cells,
// one cell per cycle; each cell compares against the single colour it
// holds and, when it is the first free cell a new colour reaches, takes it.
// Entries fill from the bottom of the chain, so every stored entry lies
// ahead of the first free cell and a request knows whether it matched
// before it reaches a place to write. Requests never overtake each other,
// so each cell sees the requests in order and the chain is fully
// pipelined: the block accepts one request per clock while the response
// side does not stall, and returns each response through the cell chain's
// registers, one per cell, and then the response register.
// A stalled response holds the whole chain, and req_ready drops with it.
// Reset clears every cell's valid flag at once; no clearing pass is needed.
// Write csr_wr_data to set top line mode (loads with a row above zero are
// skipped) only while no request is in flight.
module palette_colour_to_index (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  pcti_pkg::req_payload_type  req_payload,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output pcti_pkg::rsp_payload_type  rsp_payload,
   input  logic                       csr_wr_en,
   input  logic                       csr_wr_data
);

   logic                       top_line_only_ff;
   logic                       rsp_valid_ff;
   pcti_pkg::rsp_payload_type  rsp_payload_ff;
   pcti_pkg::rsp_payload_type  rsp_payload_in;
   logic                       advance;
   pcti_pkg::token_type        tok_chain [pcti_pkg::TOTAL_CELLS+1];
   pcti_pkg::token_type        tok_last;
   logic                       is_load;
   logic                       is_pixel;

   // Advance the whole chain whenever the response register is free or drains.
   assign advance   = !rsp_valid_ff || rsp_ready;
   assign req_ready = advance;

   // Configuration register; it is to be written only while idle, which the block does not enforce.
   always_ff @(posedge clock) begin
      if (reset) begin
         top_line_only_ff <= 1'b0;
      end else if (csr_wr_en) begin
         top_line_only_ff <= csr_wr_data;
      end
   end

   // Build the entry token; a bubble when no request is offered.
   always_comb begin
      tok_chain[0]          = '0;
      tok_chain[0].valid    = req_valid;
      tok_chain[0].kind     = req_payload.kind;
      tok_chain[0].colour   = req_payload.colour;
      tok_chain[0].column   = pcti_pkg::index_type'(req_payload.column);
      tok_chain[0].ignored  = top_line_only_ff && (req_payload.row != 10'd0);
   end

   // Palette entries.
   for (genvar i = 0; i < pcti_pkg::TABLE_DEPTH; i++) begin : g_entry
      pcti_entry_cell u_entry (
         .clock   (clock),
         .reset   (reset),
         .advance (advance),
         .tok_in  (tok_chain[i]),
         .tok_out (tok_chain[i+1])
      );
   end

   // Missing-colour store follows the palette.
   for (genvar j = 0; j < pcti_pkg::MISSING_DEPTH; j++) begin : g_miss
      pcti_miss_cell u_miss (
         .clock   (clock),
         .reset   (reset),
         .advance (advance),
         .tok_in  (tok_chain[pcti_pkg::TABLE_DEPTH+j]),
         .tok_out (tok_chain[pcti_pkg::TABLE_DEPTH+j+1])
      );
   end

   assign tok_last = tok_chain[pcti_pkg::TOTAL_CELLS];
   assign is_load  = (tok_last.kind == pcti_pkg::KIND_LOAD);
   assign is_pixel = (tok_last.kind == pcti_pkg::KIND_PIXEL);

   // Turn the token that left the chain into response flags.
   always_comb begin
      rsp_payload_in                 = '0;
      rsp_payload_in.found           = is_pixel && tok_last.hit;
      rsp_payload_in.index           = (is_pixel && tok_last.hit) ?
                                       pcti_pkg::field_index_type'(tok_last.index) : '0;
      rsp_payload_in.duplicate_error = is_load && !tok_last.ignored && tok_last.hit &&
                                       (tok_last.colour != 32'd0);
      rsp_payload_in.table_full      = is_load && !tok_last.ignored && !tok_last.hit &&
                                       !tok_last.placed;
      rsp_payload_in.row_ignored     = is_load && tok_last.ignored;
      rsp_payload_in.first_missing   = is_pixel && tok_last.recorded;
      rsp_payload_in.missing_full    = is_pixel && !tok_last.hit && !tok_last.seen &&
                                       !tok_last.recorded;
   end

   // Response register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= tok_last.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && tok_last.valid) begin
         rsp_payload_ff <= rsp_payload_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

endmodule

// ===== src/pcti_checker.sv =====
// Port-level checker for the palette colour indexer, bound to the top level.
`include "palette_colour_to_index_defines.svh"

module pcti_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       req_ready,
   input logic                       rsp_valid,
   input logic                       rsp_ready,
   input pcti_pkg::rsp_payload_type  rsp_payload
);

   logic [5:0] rsp_flags;

   assign rsp_flags = {rsp_payload.found, rsp_payload.duplicate_error,
                       rsp_payload.first_missing, rsp_payload.missing_full,
                       rsp_payload.table_full, rsp_payload.row_ignored};

   `PCTI_ASSERT(a_rsp_hold, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload), "response lost")
   `PCTI_ASSERT(a_one_flag, rsp_valid |-> $onehot0(rsp_flags), "more than one response flag set")
   `PCTI_ASSERT(a_index_zero, rsp_valid && !rsp_payload.found |-> rsp_payload.index == 8'd0, "stray index")
   `PCTI_ASSERT(a_ready_when_empty, !rsp_valid |-> req_ready, "request refused while empty")
   `PCTI_ASSERT_ALWAYS(a_reset_empty, reset |=> !rsp_valid, "response valid right after reset")

endmodule

bind palette_colour_to_index pcti_checker u_pcti_checker (.*);

// ===== verif/palette_colour_to_index_tb.sv =====
// Self-checking testbench for the palette colour indexer: directed and random requests.
module palette_colour_to_index_tb;
   import pcti_pkg::*;

   // The spare request code: the block must ignore it and answer with all zeros.
   localparam logic [1:0] KIND_SPARE = 2'd3;

   // One response register after the cell chain.
   localparam int LATENCY       = TOTAL_CELLS + 1;
   localparam int CYCLE_LIMIT   = 300000;
   localparam int ITEM_TARGET   = 1600;
   localparam int HOLD_CYCLES   = 800;
   localparam int MISS_SET_SIZE = 24;
   localparam int POOL_LIMIT    = 64;
   localparam int REPORT_LIMIT  = 50;

   // Palette and missing-color stores mirrored in software, plus the queue of
   // responses the block still owes.
   class palette_scoreboard;
      bit              top_line_only;
      int              errors;
      rsp_payload_type expected_responses[$];
      bit [31:0]       pal_color [TABLE_DEPTH];
      index_type       pal_index [TABLE_DEPTH];
      bit              pal_used  [TABLE_DEPTH];
      bit [31:0]       miss_color [MISSING_DEPTH];
      int              miss_count;

      function new();
         top_line_only = 1'b0;
         errors        = 0;
         clear_stores();
      endfunction

      function void clear_stores();
         foreach (pal_used[k]) pal_used[k] = 1'b0;
         miss_count = 0;
      endfunction

      function int find_entry(bit [31:0] color);
         for (int k = 0; k < TABLE_DEPTH; k++) begin
            if (pal_used[k] && pal_color[k] == color) return k;
         end
         return -1;
      endfunction

      // Work out the response to an accepted request and queue it.
      function void note_request(req_payload_type r);
         rsp_payload_type want;
         int              slot;
         bit              seen;
         want = '0;
         case (r.kind)
            KIND_LOAD: begin
               if (top_line_only && r.row != '0) begin
                  want.row_ignored = 1'b1;
               end else if (find_entry(r.colour) >= 0) begin
                  // Color zero repeats silently.
                  want.duplicate_error = (r.colour != '0);
               end else begin
                  slot = -1;
                  for (int k = TABLE_DEPTH - 1; k >= 0; k--) begin
                     if (!pal_used[k]) slot = k;
                  end
                  if (slot < 0) begin
                     want.table_full = 1'b1;
                  end else begin
                     pal_used[slot]  = 1'b1;
                     pal_color[slot] = r.colour;
                     pal_index[slot] = r.column[INDEX_BITS-1:0];
                  end
               end
            end
            KIND_PIXEL: begin
               slot = find_entry(r.colour);
               if (slot >= 0) begin
                  want.found = 1'b1;
                  want.index = field_index_type'(pal_index[slot]);
               end else begin
                  seen = 1'b0;
                  for (int k = 0; k < miss_count; k++) begin
                     if (miss_color[k] == r.colour) seen = 1'b1;
                  end
                  if (!seen) begin
                     if (miss_count < MISSING_DEPTH) begin
                        miss_color[miss_count] = r.colour;
                        miss_count++;
                        want.first_missing = 1'b1;
                     end else begin
                        want.missing_full = 1'b1;
                     end
                  end
               end
            end
            KIND_CLEAR: clear_stores();
            default: ;
         endcase
         expected_responses.insert(expected_responses.size(), want);
      endfunction

      function void compare_field(string name, logic [7:0] want, logic [7:0] got);
         if (got !== want) begin
            if (errors < REPORT_LIMIT)
               $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
            errors++;
         end
      endfunction

      // Compare one accepted response with the oldest owed one.
      function void check_response(rsp_payload_type got);
         rsp_payload_type want;
         if (expected_responses.size() == 0) begin
            if (errors < REPORT_LIMIT)
               $display("%0t: response %h with no request outstanding, expected none",
                        $time, got);
            errors++;
            return;
         end
         want = expected_responses.pop_front();
         compare_field("found",           8'(want.found),           8'(got.found));
         compare_field("index",           want.index,               got.index);
         compare_field("duplicate_error", 8'(want.duplicate_error), 8'(got.duplicate_error));
         compare_field("first_missing",   8'(want.first_missing),   8'(got.first_missing));
         compare_field("missing_full",    8'(want.missing_full),    8'(got.missing_full));
         compare_field("table_full",      8'(want.table_full),      8'(got.table_full));
         compare_field("row_ignored",     8'(want.row_ignored),     8'(got.row_ignored));
      endfunction
   endclass

   logic            clock       = 1'b0;
   logic            reset       = 1'b1;
   logic            req_valid   = 1'b0;
   logic            req_ready;
   req_payload_type req_payload = '0;
   logic            rsp_valid;
   logic            rsp_ready   = 1'b0;
   rsp_payload_type rsp_payload;
   logic            csr_wr_en   = 1'b0;
   logic            csr_wr_data = 1'b0;

   palette_scoreboard sb;
   int                items_sent  = 0;
   int                burst_left  = 0;
   int                cycle_count = 0;
   bit                hold_request = 1'b0;
   bit                hold_rsp     = 1'b0;
   logic [9:0]        stall_tick   = '0;
   logic              ready_pick;
   bit [31:0]         loaded_colors[$];
   bit [31:0]         miss_set[MISS_SET_SIZE];

   palette_colour_to_index u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always #1 clock = ~clock;

   // Abort a hung run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   // Check every response the moment it is taken.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) sb.check_response(rsp_payload);
   end

   // Receiver: rotate through four stall styles chosen by stall_tick[9:8] (always
   // ready, mostly ready, a fixed pattern, mostly stalled), and drop ready
   // entirely while the long hold-off runs.
   always @(negedge clock) begin
      stall_tick <= stall_tick + 1'b1;
      case (stall_tick[9:8])
         2'd0: ready_pick = 1'b1;
         2'd1: ready_pick = ($urandom_range(0, 3) != 0);
         2'd2: ready_pick = stall_tick[1] | stall_tick[3];
         default: ready_pick = ($urandom_range(0, 9) < 3);
      endcase
      rsp_ready <= ready_pick && !hold_rsp;
   end

   // Long hold-off: once asked for, stall the response side long enough for
   // the whole cell chain to fill and push back on the request side.
   initial begin
      wait (hold_request);
      @(posedge clock);
      hold_rsp = 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      hold_rsp = 1'b0;
   end

   // Offer one request and hold it until taken. Enter and leave at a falling
   // edge. Requests go out in bursts with random gaps in between.
   task automatic send_request(logic [1:0] kind, logic [31:0] color,
                               logic [7:0] column, logic [9:0] row);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 40);
         gap        = $urandom_range(0, 6);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      burst_left--;
      req_valid          <= 1'b1;
      req_payload.kind   <= kind;
      req_payload.colour <= color;
      req_payload.column <= column;
      req_payload.row    <= row;
      forever begin
         @(posedge clock);
         if (req_valid && req_ready) break;
      end
      sb.note_request(req_payload);
      items_sent++;
      @(negedge clock);
   endtask

   // Drop valid and wait until every owed response is back.
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (sb.expected_responses.size() != 0) @(negedge clock);
      @(negedge clock);
   endtask

   // Write top line mode; call only while idle.
   task automatic write_top_line(logic value);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
      sb.top_line_only = value;
   endtask

   // Remember a loaded color so later pixels and loads can hit it.
   function automatic void remember_color(bit [31:0] color);
      loaded_colors.insert(loaded_colors.size(), color);
      if (loaded_colors.size() > POOL_LIMIT) void'(loaded_colors.pop_front());
   endfunction

   // Mix known palette colors, zero, a small set of recurring misses and
   // fresh random colors.
   function automatic bit [31:0] pick_color();
      int r;
      r = $urandom_range(0, 99);
      if (r < 35 && loaded_colors.size() > 0)
         return loaded_colors[$urandom_range(0, loaded_colors.size() - 1)];
      if (r < 45) return '0;
      if (r < 70) return miss_set[$urandom_range(0, MISS_SET_SIZE - 1)];
      return $urandom;
   endfunction

   // Row zero most of the time, any row one time in odds.
   function automatic logic [9:0] pick_row(int odds);
      logic [9:0] row;
      row = 10'($urandom);
      return ($urandom_range(0, odds - 1) == 0) ? row : 10'd0;
   endfunction

   // Clear, load past the palette capacity, then miss past the missing store.
   task automatic run_fill_phase();
      int        loads;
      bit [31:0] color;
      send_request(KIND_CLEAR, $urandom, 8'($urandom), 10'($urandom));
      loads = $urandom_range(270, 310);
      for (int k = 0; k < loads; k++) begin
         if ($urandom_range(0, 4) == 0)
            send_request(KIND_PIXEL, pick_color(), 8'($urandom), 10'($urandom));
         color = $urandom;
         if ($urandom_range(0, 19) == 0 && loaded_colors.size() > 0)
            color = loaded_colors[$urandom_range(0, loaded_colors.size() - 1)];
         remember_color(color);
         send_request(KIND_LOAD, color, 8'($urandom), pick_row(20));
      end
      for (int k = 0; k < 40; k++)
         send_request(KIND_PIXEL, $urandom, 8'($urandom), 10'($urandom));
   endtask

   // Random mix of all request codes.
   task automatic run_mixed_phase();
      int         count;
      int         r;
      logic [1:0] kind;
      bit [31:0]  color;
      count = $urandom_range(150, 250);
      for (int k = 0; k < count; k++) begin
         r = $urandom_range(0, 99);
         if (r < 40)      kind = KIND_LOAD;
         else if (r < 94) kind = KIND_PIXEL;
         else if (r < 97) kind = KIND_CLEAR;
         else             kind = KIND_SPARE;
         color = pick_color();
         if (kind == KIND_LOAD) remember_color(color);
         send_request(kind, color, 8'($urandom), pick_row(4));
      end
   endtask

   initial begin
      int phase;
      sb = new();
      foreach (miss_set[k]) miss_set[k] = $urandom;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      write_top_line(1'b0);

      // Directed: misses, color zero rules, duplicates, extremes, spare code, clear.
      send_request(KIND_PIXEL, 32'h0000_0000, 8'h00, 10'h000);
      send_request(KIND_PIXEL, 32'h0000_0000, 8'hFF, 10'h3FF);
      send_request(KIND_LOAD,  32'h0000_0000, 8'hFF, 10'h000);
      send_request(KIND_LOAD,  32'h0000_0000, 8'h12, 10'h000);
      send_request(KIND_PIXEL, 32'h0000_0000, 8'h00, 10'h000);
      send_request(KIND_LOAD,  32'hFFFF_FFFF, 8'h00, 10'h3FF);
      send_request(KIND_LOAD,  32'hFFFF_FFFF, 8'h55, 10'h000);
      send_request(KIND_PIXEL, 32'hFFFF_FFFF, 8'hFF, 10'h3FF);
      send_request(KIND_SPARE, 32'hFFFF_FFFF, 8'hFF, 10'h3FF);
      send_request(KIND_CLEAR, 32'hFFFF_FFFF, 8'hFF, 10'h3FF);
      send_request(KIND_PIXEL, 32'hFFFF_FFFF, 8'h00, 10'h000);
      send_request(KIND_LOAD,  32'hA5A5_A5A5, 8'hAA, 10'h2AA);
      send_request(KIND_PIXEL, 32'hA5A5_A5A5, 8'h00, 10'h000);

      // Directed, top line mode: skip rows above zero, keep row zero.
      wait_idle();
      write_top_line(1'b1);
      send_request(KIND_LOAD,  32'h1234_5678, 8'h01, 10'h001);
      send_request(KIND_LOAD,  32'h1234_5678, 8'h01, 10'h3FF);
      send_request(KIND_LOAD,  32'h1234_5678, 8'h7E, 10'h000);
      send_request(KIND_PIXEL, 32'h1234_5678, 8'h00, 10'h155);
      send_request(KIND_LOAD,  32'h0000_0000, 8'h33, 10'h200);
      send_request(KIND_LOAD,  32'hA5A5_A5A5, 8'h00, 10'h000);
      send_request(KIND_CLEAR, 32'h0000_0000, 8'h00, 10'h000);
      send_request(KIND_PIXEL, 32'h1234_5678, 8'h00, 10'h000);

      // Random phases: pause until drained, flip top line mode, then run a
      // fill phase every third time and a mixed phase otherwise. The first
      // fill phase also triggers the long response hold-off.
      phase = 0;
      while (items_sent < ITEM_TARGET) begin
         wait_idle();
         write_top_line(phase % 2 == 1);
         if (phase % 3 == 0) begin
            if (phase == 0) hold_request = 1'b1;
            run_fill_phase();
         end else begin
            run_mixed_phase();
         end
         phase++;
      end

      wait_idle();
      repeat (LATENCY + 20) @(negedge clock);
      if (sb.errors == 0 && sb.expected_responses.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
+incdir+src
src/pcti_pkg.sv
src/pcti_entry_cell.sv
src/pcti_miss_cell.sv
src/palette_colour_to_index.sv
src/pcti_checker.sv
verif/palette_colour_to_index_tb.sv
